FILE: hw/rtl/qnlerp_pkg.sv
`default_nettype none
package qnlerp_pkg;

  localparam int unsigned NumComp  = 4;
  localparam int unsigned CompW    = 16;
  localparam int unsigned BlendW   = 15;
  localparam int unsigned FracW    = 14;
  localparam int unsigned QOne     = 16384;
  localparam int unsigned DiffW    = 18;  // (+-b) - a
  localparam int unsigned ProdW    = 36;  // diff * t, plus a << 14
  localparam int unsigned RW       = 31;  // blended component, Q.28
  localparam int unsigned SqW      = 59;  // r * r
  localparam int unsigned SumW     = 61;  // sum of four squares
  localparam int unsigned RootW    = 63;  // isqrt remainder / partial root
  localparam int unsigned RootStep = 31;  // one result bit per step
  localparam int unsigned LenW     = 31;
  localparam int unsigned MagW     = 30;
  localparam int unsigned DivW     = 47;  // dividend / partial remainder
  localparam int unsigned QuotW    = 16;
  localparam int unsigned ValW     = 17;
  localparam int unsigned InDataW  = 144;
  localparam int unsigned OutDataW = 64;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [RW-1:0]    blend_r_t;
  typedef logic [RootW-1:0]        root_t;
  typedef logic [DivW-1:0]         div_t;

endpackage
`default_nettype wire

FILE: hw/rtl/quaternion_nlerp_core.sv
`default_nettype none
// Quaternion nlerp, fixed point. Each input beat carries a start quaternion
// qa, an end quaternion qb (signed Q1.14) and a blend factor t (unsigned
// Q1.14, clamped to one). qb is negated when qa.qb < 0, r = qa + (qb-qa)*t is
// formed exactly, divided by its Euclidean length, rounded to nearest (ties
// away from zero) and saturated to Q1.14. If the length is below one LSB, r
// is only rounded and tuser (not_normalized) is set. Throughput is one beat
// per clock while the output is not stalled. The pipe has 4 front stages
// (products, dot sign, blend, squares), the sum stage, 31 square-root stages
// (one result bit each), 1 dividend stage, 16 divider stages (one quotient
// bit each, four lanes) and 1 output register. The whole pipe advances
// together; a stalled output holds every stage and drops tready.
module quaternion_nlerp_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // qa_x, qa_y, qa_z, qa_w, qb_x, qb_y, qb_z, qb_w (16 b each), blend (15 b), pad
  input  wire logic [qnlerp_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // res_x, res_y, res_z, res_w (16 b each)
  output logic [qnlerp_pkg::OutDataW-1:0]        m_axis_tdata_o,
  // not_normalized
  output logic                                   m_axis_tuser_o
);

  localparam int unsigned NC = qnlerp_pkg::NumComp;
  localparam int unsigned NR = qnlerp_pkg::RootStep;
  localparam int unsigned NQ = qnlerp_pkg::QuotW;

  logic en;
  assign en = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // ---------------- stage 1: dot products, clamp t
  logic                              s1_v_q;
  qnlerp_pkg::comp_t                 s1_a_q [NC];
  qnlerp_pkg::comp_t                 s1_b_q [NC];
  logic signed [31:0]                s1_p_q [NC];
  logic [qnlerp_pkg::BlendW-1:0]     s1_t_q;
  logic [qnlerp_pkg::BlendW-1:0]     blend_in;

  assign blend_in = s_axis_tdata_i[142:128];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        s1_a_q[i] <= s_axis_tdata_i[16*i +: 16];
        s1_b_q[i] <= s_axis_tdata_i[16*(i+4) +: 16];
        s1_p_q[i] <= $signed(s_axis_tdata_i[16*i +: 16])
                   * $signed(s_axis_tdata_i[16*(i+4) +: 16]);
      end
      s1_t_q <= (blend_in > qnlerp_pkg::BlendW'(qnlerp_pkg::QOne))
              ? qnlerp_pkg::BlendW'(qnlerp_pkg::QOne) : blend_in;
    end
  end

  // ---------------- stage 2: dot sign, difference
  logic                                  s2_v_q;
  qnlerp_pkg::comp_t                     s2_a_q [NC];
  logic signed [qnlerp_pkg::DiffW-1:0]   s2_d_q [NC];
  logic [qnlerp_pkg::BlendW-1:0]         s2_t_q;
  logic signed [33:0]                    dot;
  logic signed [qnlerp_pkg::DiffW-1:0]   bx [NC];

  always_comb begin
    dot = '0;
    for (int i = 0; i < NC; i++) begin
      dot = dot + 34'(s1_p_q[i]);
    end
    for (int i = 0; i < NC; i++) begin
      bx[i] = dot[33] ? -qnlerp_pkg::DiffW'(s1_b_q[i]) : qnlerp_pkg::DiffW'(s1_b_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        s2_a_q[i] <= s1_a_q[i];
        s2_d_q[i] <= bx[i] - qnlerp_pkg::DiffW'(s1_a_q[i]);
      end
      s2_t_q <= s1_t_q;
    end
  end

  // ---------------- stage 3: blend r = a*2^14 + d*t
  logic                           s3_v_q;
  qnlerp_pkg::blend_r_t           s3_r_q [NC];
  logic signed [qnlerp_pkg::ProdW-1:0] dt_prod [NC];
  logic signed [qnlerp_pkg::ProdW-1:0] r_full [NC];

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      dt_prod[i] = s2_d_q[i] * $signed({3'b000, s2_t_q});
      r_full[i]  = (qnlerp_pkg::ProdW'(s2_a_q[i]) <<< qnlerp_pkg::FracW) + dt_prod[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        s3_r_q[i] <= r_full[i][qnlerp_pkg::RW-1:0];
      end
    end
  end

  // ---------------- stage 4: squares
  logic                           s4_v_q;
  qnlerp_pkg::blend_r_t           s4_r_q [NC];
  logic [qnlerp_pkg::SqW-1:0]     s4_sq_q [NC];
  logic signed [2*qnlerp_pkg::RW-1:0] sq_full [NC];

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      sq_full[i] = s3_r_q[i] * s3_r_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        s4_r_q[i]  <= s3_r_q[i];
        s4_sq_q[i] <= sq_full[i][qnlerp_pkg::SqW-1:0];
      end
    end
  end

  // ---------------- square root: entry 0 holds the sum of squares, then one bit per stage
  logic                      rt_v_q   [NR+1];
  qnlerp_pkg::root_t         rt_rem_q [NR+1];
  qnlerp_pkg::root_t         rt_res_q [NR+1];
  logic                      rt_sm_q  [NR+1];
  qnlerp_pkg::blend_r_t      rt_r_q   [NR+1][NC];
  logic [qnlerp_pkg::SumW-1:0] sumsq;
  qnlerp_pkg::root_t         rt_rem_d [NR];
  qnlerp_pkg::root_t         rt_res_d [NR];

  always_comb begin
    qnlerp_pkg::root_t bitv;
    qnlerp_pkg::root_t trial;
    sumsq = '0;
    for (int i = 0; i < NC; i++) begin
      sumsq = sumsq + qnlerp_pkg::SumW'(s4_sq_q[i]);
    end
    for (int k = 0; k < NR; k++) begin
      bitv  = qnlerp_pkg::root_t'(1) << (2 * (NR - 1 - k));
      trial = rt_res_q[k] + bitv;
      if (rt_rem_q[k] >= trial) begin
        rt_rem_d[k] = rt_rem_q[k] - trial;
        rt_res_d[k] = (rt_res_q[k] >> 1) + bitv;
      end else begin
        rt_rem_d[k] = rt_rem_q[k];
        rt_res_d[k] = rt_res_q[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt_rem_q[0] <= qnlerp_pkg::RootW'(sumsq);
      rt_res_q[0] <= '0;
      rt_sm_q[0]  <= (sumsq < (qnlerp_pkg::SumW'(1) << (2 * qnlerp_pkg::FracW)));
      rt_r_q[0]   <= s4_r_q;
      for (int k = 0; k < NR; k++) begin
        rt_rem_q[k+1] <= rt_rem_d[k];
        rt_res_q[k+1] <= rt_res_d[k];
        rt_sm_q[k+1]  <= rt_sm_q[k];
        rt_r_q[k+1]   <= rt_r_q[k];
      end
    end
  end

  // ---------------- divider: entry 0 holds dividends, then one quotient bit per stage
  logic                         dv_v_q   [NQ+1];
  qnlerp_pkg::div_t             dv_rem_q [NQ+1][NC];
  logic [qnlerp_pkg::QuotW-1:0] dv_q_q   [NQ+1][NC];
  logic                         dv_neg_q [NQ+1][NC];
  logic [qnlerp_pkg::ValW-1:0]  dv_smq_q [NQ+1][NC];
  logic [qnlerp_pkg::LenW-1:0]  dv_len_q [NQ+1];
  logic                         dv_sm_q  [NQ+1];
  logic [qnlerp_pkg::LenW-1:0]  len;
  logic [qnlerp_pkg::MagW-1:0]  mag [NC];
  qnlerp_pkg::div_t             dv_rem_d [NQ][NC];
  logic [qnlerp_pkg::QuotW-1:0] dv_q_d   [NQ][NC];

  assign len = rt_res_q[NR][qnlerp_pkg::LenW-1:0];

  always_comb begin
    qnlerp_pkg::div_t dsub;
    for (int i = 0; i < NC; i++) begin
      mag[i] = rt_r_q[NR][i][qnlerp_pkg::RW-1]
             ? qnlerp_pkg::MagW'(-rt_r_q[NR][i]) : qnlerp_pkg::MagW'(rt_r_q[NR][i]);
    end
    for (int k = 0; k < NQ; k++) begin
      dsub = qnlerp_pkg::div_t'(dv_len_q[k]) << (NQ - 1 - k);
      for (int i = 0; i < NC; i++) begin
        dv_q_d[k][i] = dv_q_q[k][i];
        if (dv_rem_q[k][i] >= dsub) begin
          dv_rem_d[k][i] = dv_rem_q[k][i] - dsub;
          dv_q_d[k][i][NQ-1-k] = 1'b1;
        end else begin
          dv_rem_d[k][i] = dv_rem_q[k][i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        dv_rem_q[0][i] <= (qnlerp_pkg::div_t'(mag[i]) << qnlerp_pkg::FracW)
                        + qnlerp_pkg::div_t'(len >> 1);
        dv_q_q[0][i]   <= '0;
        dv_neg_q[0][i] <= rt_r_q[NR][i][qnlerp_pkg::RW-1];
        dv_smq_q[0][i] <= qnlerp_pkg::ValW'((32'(mag[i]) + 32'(qnlerp_pkg::QOne / 2))
                                            >> qnlerp_pkg::FracW);
      end
      dv_len_q[0] <= len;
      dv_sm_q[0]  <= rt_sm_q[NR];
      for (int k = 0; k < NQ; k++) begin
        dv_rem_q[k+1] <= dv_rem_d[k];
        dv_q_q[k+1]   <= dv_q_d[k];
        dv_neg_q[k+1] <= dv_neg_q[k];
        dv_smq_q[k+1] <= dv_smq_q[k];
        dv_len_q[k+1] <= dv_len_q[k];
        dv_sm_q[k+1]  <= dv_sm_q[k];
      end
    end
  end

  // ---------------- output: sign, saturate
  logic [qnlerp_pkg::OutDataW-1:0] out_d;
  logic [qnlerp_pkg::OutDataW-1:0] out_q;
  logic                            out_nn_q;

  always_comb begin
    logic [qnlerp_pkg::ValW-1:0] val;
    logic signed [qnlerp_pkg::ValW:0] sv;
    for (int i = 0; i < NC; i++) begin
      val = dv_sm_q[NQ] ? dv_smq_q[NQ][i] : qnlerp_pkg::ValW'(dv_q_q[NQ][i]);
      sv  = dv_neg_q[NQ][i] ? -$signed({1'b0, val}) : $signed({1'b0, val});
      if (sv > 18'sd32767) begin
        out_d[16*i +: 16] = 16'h7FFF;
      end else if (sv < -18'sd32768) begin
        out_d[16*i +: 16] = 16'h8000;
      end else begin
        out_d[16*i +: 16] = sv[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q    <= out_d;
      out_nn_q <= dv_sm_q[NQ];
    end
  end

  assign m_axis_tdata_o = out_q;
  assign m_axis_tuser_o = out_nn_q;

  // ---------------- valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      for (int k = 0; k <= NR; k++) rt_v_q[k] <= 1'b0;
      for (int k = 0; k <= NQ; k++) dv_v_q[k] <= 1'b0;
      m_axis_tvalid_o <= 1'b0;
    end else if (en) begin
      s1_v_q    <= s_axis_tvalid_i;
      s2_v_q    <= s1_v_q;
      s3_v_q    <= s2_v_q;
      s4_v_q    <= s3_v_q;
      rt_v_q[0] <= s4_v_q;
      for (int k = 0; k < NR; k++) rt_v_q[k+1] <= rt_v_q[k];
      dv_v_q[0] <= rt_v_q[NR];
      for (int k = 0; k < NQ; k++) dv_v_q[k+1] <= dv_v_q[k];
      m_axis_tvalid_o <= dv_v_q[NQ];
    end
  end

`ifndef SYNTHESIS
  // normalized length is at least one LSB
  a_root_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rt_v_q[NR] && !rt_sm_q[NR] |-> len >= qnlerp_pkg::LenW'(qnlerp_pkg::QOne))
    else $error("root below one LSB on normalized path");

  // divider remainder ends below the divisor (checked on lanes 0 and 3)
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[NQ] && !dv_sm_q[NQ] |->
      dv_rem_q[NQ][0] < qnlerp_pkg::div_t'(dv_len_q[NQ]) &&
      dv_rem_q[NQ][3] < qnlerp_pkg::div_t'(dv_len_q[NQ]))
    else $error("divider remainder out of range");

  // unnormalized results are tiny (checked on res_x)
  a_small_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      ($signed(m_axis_tdata_o[15:0]) <= 16'sd1 && $signed(m_axis_tdata_o[15:0]) >= -16'sd1))
    else $error("unnormalized result too large");

  // normalized components stay within unit magnitude (checked on res_w)
  a_unit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      ($signed(m_axis_tdata_o[63:48]) <= 16'sd16384 &&
       $signed(m_axis_tdata_o[63:48]) >= -16'sd16384))
    else $error("normalized component above one");
`endif

endmodule
`default_nettype wire
